@@ design/rgb_to_hsv_converter_core_defines.svh @@
// Assertion macros shared by the RGB to HSV converter RTL.
// Self-contained: no dependencies on other files.
`ifndef RGB_TO_HSV_CONVERTER_CORE_DEFINES_SVH
`define RGB_TO_HSV_CONVERTER_CORE_DEFINES_SVH

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define RHC_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("rgb_to_hsv_converter_core: same-cycle check failed");

// Whenever the antecedent holds, the consequent must hold in the next cycle.
`define RHC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("rgb_to_hsv_converter_core: next-cycle check failed");

`endif

@@ design/rhc_pkg.sv @@
// Shared types and constants for the RGB to HSV converter.
// Used by every module of the block; no dependencies.
package rhc_pkg;

  // Which component holds the maximum; ties go to red, then green.
  typedef enum logic [1:0] {
    SECTOR_RED,
    SECTOR_GREEN,
    SECTOR_BLUE
  } sector_e;

  // Control information that rides alongside the hue division.
  typedef struct packed {
    logic    grey;    // max equals min: hue and saturation are zero
    sector_e sector;  // dominant component
    logic    neg;     // the hue offset is subtracted from the sector base
  } hue_side_t;

  localparam int unsigned HUE_SECTOR_DEG = 60;
  localparam int unsigned HUE_GREEN_DEG  = 120;
  localparam int unsigned HUE_BLUE_DEG   = 240;
  localparam int unsigned HUE_FULL_DEG   = 360;
  localparam int unsigned HUE_INT_BITS   = 9;   // holds 0 to 359 degrees
  localparam int unsigned SECTOR_BITS    = 6;   // holds 60 degrees

endpackage

@@ design/rgb_to_hsv_converter_core.sv @@
// Top level of the RGB to HSV converter: front end, two dividers, back end.
// Depends on rhc_pkg, rhc_front, rhc_div, rhc_back and the assertion macros.
//
// Usage: pixels enter on the input channel (in_valid_i / in_ready_o with
// red_i, green_i, blue_i) and leave on the output channel (out_valid_o /
// out_ready_i with hue_o, saturation_o, value_o). Each transfer carries one
// pixel and yields exactly one result transfer, in the same order.
// Hue is in degrees with HUE_FRAC_BITS fractional bits, saturation is a
// fraction with SAT_FRAC_BITS fractional bits, value is the largest component.
// From input transfer to result valid a pixel passes stage one and stage two
// of the front end, the DivDepth divider stages and the output register, where
// DivDepth = max(HUE_FRAC_BITS + 6, SAT_FRAC_BITS + 1). The two divisions each
// retire one quotient bit per stage, which sets the pipeline depth.
// Throughput is one pixel per clock while the receiver accepts results.
// The whole pipeline advances together: when a result waits at the output
// and the receiver holds out_ready_i low, every stage freezes and in_ready_o
// drops, so nothing is lost or repeated. Bubbles are kept in place.
// Reset clears every valid bit; the payload registers are not reset, and
// the block is ready to accept a pixel as soon as reset is released.
`include "rgb_to_hsv_converter_core_defines.svh"

module rgb_to_hsv_converter_core import rhc_pkg::*; #(
  parameter int unsigned COMPONENT_BITS = 8,
  parameter int unsigned HUE_FRAC_BITS  = 6,
  parameter int unsigned SAT_FRAC_BITS  = 8
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [COMPONENT_BITS-1:0]              red_i,
  input  logic [COMPONENT_BITS-1:0]              green_i,
  input  logic [COMPONENT_BITS-1:0]              blue_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [HUE_INT_BITS+HUE_FRAC_BITS-1:0]  hue_o,
  output logic [SAT_FRAC_BITS:0]                 saturation_o,
  output logic [COMPONENT_BITS-1:0]              value_o
);

  localparam int unsigned HueW  = HUE_INT_BITS + HUE_FRAC_BITS;
  localparam int unsigned QhW   = SECTOR_BITS + HUE_FRAC_BITS;
  localparam int unsigned SatW  = SAT_FRAC_BITS + 1;
  localparam int unsigned NumHW = COMPONENT_BITS + SECTOR_BITS + HUE_FRAC_BITS;
  localparam int unsigned NumSW = COMPONENT_BITS + SAT_FRAC_BITS;
  // Both dividers share one depth so that their results line up.
  localparam int unsigned DivDepth = (QhW > SatW) ? QhW : SatW;
  localparam int unsigned SideW    = $bits(hue_side_t);
  localparam logic [HueW-1:0] FullTurn = HueW'(HUE_FULL_DEG) << HUE_FRAC_BITS;

  // Global advance: the pipeline moves whenever the output register is free
  // or its result is being transferred in this cycle.
  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  logic                      fe_vld;
  logic [NumHW-1:0]          fe_num_h;
  logic [NumSW-1:0]          fe_num_s;
  logic [COMPONENT_BITS-1:0] fe_delta, fe_max;
  hue_side_t                 fe_side;

  rhc_front #(
    .COMPONENT_BITS (COMPONENT_BITS),
    .HUE_FRAC_BITS  (HUE_FRAC_BITS),
    .SAT_FRAC_BITS  (SAT_FRAC_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (in_valid_i),
    .red_i   (red_i),
    .green_i (green_i),
    .blue_i  (blue_i),
    .vld_o   (fe_vld),
    .num_h_o (fe_num_h),
    .num_s_o (fe_num_s),
    .delta_o (fe_delta),
    .max_o   (fe_max),
    .side_o  (fe_side)
  );

  // Hue divider: 60 * |difference| scaled, over max - min. The sector
  // information rides along as sideband.
  logic                 hdiv_vld;
  logic [DivDepth-1:0]  hdiv_quo;
  logic [SideW-1:0]     hdiv_side_in, hdiv_side;

  assign hdiv_side_in = fe_side;

  rhc_div #(
    .NUM_W  (NumHW),
    .DEN_W  (COMPONENT_BITS),
    .DEPTH  (DivDepth),
    .SIDE_W (SideW)
  ) u_hue_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (fe_vld),
    .num_i  (fe_num_h),
    .den_i  (fe_delta),
    .side_i (hdiv_side_in),
    .vld_o  (hdiv_vld),
    .quo_o  (hdiv_quo),
    .side_o (hdiv_side)
  );

  // Saturation divider: (max - min) scaled, over max. The value rides along.
  logic                      sdiv_vld;
  logic [DivDepth-1:0]       sdiv_quo;
  logic [COMPONENT_BITS-1:0] sdiv_value;

  rhc_div #(
    .NUM_W  (NumSW),
    .DEN_W  (COMPONENT_BITS),
    .DEPTH  (DivDepth),
    .SIDE_W (COMPONENT_BITS)
  ) u_sat_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (fe_vld),
    .num_i  (fe_num_s),
    .den_i  (fe_max),
    .side_i (fe_max),
    .vld_o  (sdiv_vld),
    .quo_o  (sdiv_quo),
    .side_o (sdiv_value)
  );

  // The quotients are known to fit the narrower result fields: the hue
  // offset never exceeds 60 degrees and the saturation never exceeds one.
  rhc_back #(
    .COMPONENT_BITS (COMPONENT_BITS),
    .HUE_FRAC_BITS  (HUE_FRAC_BITS),
    .SAT_FRAC_BITS  (SAT_FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .vld_i        (hdiv_vld),
    .quo_h_i      (hdiv_quo[QhW-1:0]),
    .quo_s_i      (sdiv_quo[SatW-1:0]),
    .side_i       (hue_side_t'(hdiv_side)),
    .value_i      (sdiv_value),
    .vld_o        (out_valid_o),
    .hue_o        (hue_o),
    .saturation_o (saturation_o),
    .value_o      (value_o)
  );

  // The two dividers run in lock step, so their valid bits always agree.
  `RHC_ASSERT_IMPL(a_div_lockstep, clk_i, rst_ni, 1'b1, hdiv_vld == sdiv_vld)
  // A black pixel has neither hue nor saturation.
  `RHC_ASSERT_IMPL(a_black_zero, clk_i, rst_ni, out_valid_o && (value_o == '0),
                   (hue_o == '0) && (saturation_o == '0))
  // Hue always stays below a full turn after the wrap.
  `RHC_ASSERT_IMPL(a_hue_range, clk_i, rst_ni, out_valid_o, hue_o < FullTurn)
  // A divider result held up by a stall is still there in the next cycle.
  `RHC_ASSERT_NEXT(a_stall_freeze, clk_i, rst_ni, hdiv_vld && !en, hdiv_vld)

endmodule

@@ design/rhc_front.sv @@
// Front end of the converter: max/min search, sector choice and numerators.
// Depends on rhc_pkg.
module rhc_front import rhc_pkg::*; #(
  parameter int unsigned COMPONENT_BITS = 8,
  parameter int unsigned HUE_FRAC_BITS  = 6,
  parameter int unsigned SAT_FRAC_BITS  = 8,
  localparam int unsigned NumHW = COMPONENT_BITS + SECTOR_BITS + HUE_FRAC_BITS,
  localparam int unsigned NumSW = COMPONENT_BITS + SAT_FRAC_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      vld_i,
  input  logic [COMPONENT_BITS-1:0] red_i,
  input  logic [COMPONENT_BITS-1:0] green_i,
  input  logic [COMPONENT_BITS-1:0] blue_i,
  output logic                      vld_o,
  output logic [NumHW-1:0]          num_h_o,
  output logic [NumSW-1:0]          num_s_o,
  output logic [COMPONENT_BITS-1:0] delta_o,
  output logic [COMPONENT_BITS-1:0] max_o,
  output hue_side_t                 side_o
);

  // Stage one: extremes, sector and the signed hue difference.
  logic                      s1_vld_q;
  logic [COMPONENT_BITS-1:0] mx_d, mx_q, mn_d, mn_q, mag_d, mag_q;
  sector_e                   sector_d, sector_q;
  logic                      neg_d, neg_q;

  always_comb begin
    logic [COMPONENT_BITS-1:0] a, b;
    if (red_i >= green_i && red_i >= blue_i) begin
      sector_d = SECTOR_RED;
      mx_d     = red_i;
      a        = green_i;
      b        = blue_i;
    end else if (green_i >= blue_i) begin
      sector_d = SECTOR_GREEN;
      mx_d     = green_i;
      a        = blue_i;
      b        = red_i;
    end else begin
      sector_d = SECTOR_BLUE;
      mx_d     = blue_i;
      a        = red_i;
      b        = green_i;
    end
    mn_d = red_i;
    if (green_i < mn_d) mn_d = green_i;
    if (blue_i < mn_d) mn_d = blue_i;
    neg_d = (a < b);
    mag_d = neg_d ? (b - a) : (a - b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en_i) begin
      s1_vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mx_q     <= mx_d;
      mn_q     <= mn_d;
      mag_q    <= mag_d;
      sector_q <= sector_d;
      neg_q    <= neg_d;
    end
  end

  // Stage two: range, scaled numerators for both divisions.
  logic                      s2_vld_q;
  logic [COMPONENT_BITS-1:0] delta_d;
  logic [NumHW-1:0]          num_h_d, num_h_q;
  logic [NumSW-1:0]          num_s_d, num_s_q;
  logic [COMPONENT_BITS-1:0] delta_q, max_q;
  hue_side_t                 side_d, side_q;

  always_comb begin
    delta_d       = mx_q - mn_q;
    num_h_d       = (NumHW'(mag_q) * NumHW'(HUE_SECTOR_DEG)) << HUE_FRAC_BITS;
    num_s_d       = NumSW'(delta_d) << SAT_FRAC_BITS;
    side_d.grey   = (delta_d == '0);
    side_d.sector = sector_q;
    side_d.neg    = neg_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en_i) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_h_q <= num_h_d;
      num_s_q <= num_s_d;
      delta_q <= delta_d;
      max_q   <= mx_q;
      side_q  <= side_d;
    end
  end

  assign vld_o   = s2_vld_q;
  assign num_h_o = num_h_q;
  assign num_s_o = num_s_q;
  assign delta_o = delta_q;
  assign max_o   = max_q;
  assign side_o  = side_q;

endmodule

@@ design/rhc_div.sv @@
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on rhc_pkg only through the importing convention; generic otherwise.
module rhc_div import rhc_pkg::*; #(
  parameter int unsigned NUM_W  = 20,
  parameter int unsigned DEN_W  = 8,
  parameter int unsigned DEPTH  = 12,
  parameter int unsigned SIDE_W = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output logic [DEPTH-1:0]  quo_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int unsigned RemW = (NUM_W > DEN_W + DEPTH) ? NUM_W : DEN_W + DEPTH;

  // The quotient must fit in DEPTH bits; the caller guarantees it.
  logic [DEPTH-1:0]  vld_q;
  logic [RemW-1:0]   rem_q  [DEPTH-1];
  logic [DEN_W-1:0]  den_q  [DEPTH-1];
  logic [DEPTH-1:0]  quo_q  [DEPTH];
  logic [SIDE_W-1:0] side_q [DEPTH];

  for (genvar s = 0; s < DEPTH; s++) begin : g_stage
    localparam int unsigned K = DEPTH - 1 - s;

    logic              vld_in;
    logic [RemW-1:0]   rem_in, trial, rem_d;
    logic [DEN_W-1:0]  den_in;
    logic [DEPTH-1:0]  quo_in, quo_d;
    logic [SIDE_W-1:0] side_in;

    if (s == 0) begin : g_first
      assign vld_in  = vld_i;
      assign rem_in  = RemW'(num_i);
      assign den_in  = den_i;
      assign quo_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign den_in  = den_q[s-1];
      assign quo_in  = quo_q[s-1];
      assign side_in = side_q[s-1];
    end

    always_comb begin
      trial = RemW'(den_in) << K;
      rem_d = rem_in;
      quo_d = quo_in;
      if (rem_in >= trial) begin
        rem_d    = rem_in - trial;
        quo_d[K] = 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[s]  <= quo_d;
        side_q[s] <= side_in;
      end
    end

    if (s < DEPTH - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s] <= rem_d;
          den_q[s] <= den_in;
        end
      end
    end
  end

  assign vld_o  = vld_q[DEPTH-1];
  assign quo_o  = quo_q[DEPTH-1];
  assign side_o = side_q[DEPTH-1];

endmodule

@@ design/rhc_back.sv @@
// Back end of the converter: sector offset, hue wrap and the output register.
// Depends on rhc_pkg.
module rhc_back import rhc_pkg::*; #(
  parameter int unsigned COMPONENT_BITS = 8,
  parameter int unsigned HUE_FRAC_BITS  = 6,
  parameter int unsigned SAT_FRAC_BITS  = 8,
  localparam int unsigned HueW = HUE_INT_BITS + HUE_FRAC_BITS,
  localparam int unsigned QhW  = SECTOR_BITS + HUE_FRAC_BITS,
  localparam int unsigned SatW = SAT_FRAC_BITS + 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      vld_i,
  input  logic [QhW-1:0]            quo_h_i,
  input  logic [SatW-1:0]           quo_s_i,
  input  hue_side_t                 side_i,
  input  logic [COMPONENT_BITS-1:0] value_i,
  output logic                      vld_o,
  output logic [HueW-1:0]           hue_o,
  output logic [SatW-1:0]           saturation_o,
  output logic [COMPONENT_BITS-1:0] value_o
);

  localparam logic [HueW:0] BaseGreen = (HueW+1)'(HUE_GREEN_DEG) << HUE_FRAC_BITS;
  localparam logic [HueW:0] BaseBlue  = (HueW+1)'(HUE_BLUE_DEG) << HUE_FRAC_BITS;
  localparam logic [HueW:0] FullTurn  = (HueW+1)'(HUE_FULL_DEG) << HUE_FRAC_BITS;

  logic            vld_q;
  logic [HueW:0]   base, sum;
  logic [HueW-1:0] hue_d, hue_q;
  logic [SatW-1:0] sat_d, sat_q;
  logic [COMPONENT_BITS-1:0] value_q;

  // The top bit of sum acts as a sign: every legal sum lies within +/-300 degrees.
  always_comb begin
    case (side_i.sector)
      SECTOR_RED:   base = '0;
      SECTOR_GREEN: base = BaseGreen;
      SECTOR_BLUE:  base = BaseBlue;
      default:      base = '0;
    endcase
    sum = side_i.neg ? (base - (HueW+1)'(quo_h_i)) : (base + (HueW+1)'(quo_h_i));
    if (sum[HueW]) begin
      sum = sum + FullTurn;
    end
    hue_d = side_i.grey ? '0 : sum[HueW-1:0];
    sat_d = side_i.grey ? '0 : quo_s_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hue_q   <= hue_d;
      sat_q   <= sat_d;
      value_q <= value_i;
    end
  end

  assign vld_o        = vld_q;
  assign hue_o        = hue_q;
  assign saturation_o = sat_q;
  assign value_o      = value_q;

endmodule

@@ tb/tb_rgb_to_hsv_converter_core.sv @@
// Self-checking testbench for the RGB to HSV converter core: a directed table
// followed by random pixels, with random idling on both channels.
// Depends on rhc_pkg and rgb_to_hsv_converter_core only.
module tb_rgb_to_hsv_converter_core import rhc_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COMP_BITS = 8;
  localparam int unsigned HUE_FRAC  = 6;
  localparam int unsigned SAT_FRAC  = 8;
  localparam int unsigned HUE_BITS  = HUE_INT_BITS + HUE_FRAC;
  localparam int unsigned SAT_BITS  = SAT_FRAC + 1;

  localparam int unsigned RANDOM_PIXELS   = 1700;
  localparam int unsigned NUM_DIRECTED    = 20;
  // The output side stops accepting for this long once, to fill the pipeline.
  localparam int unsigned HOLD_OFF_CYCLES = 80;
  localparam int unsigned HOLD_OFF_AT     = 300;
  // Neither side idles while results in this window are being transferred.
  localparam int unsigned CALM_FIRST      = 700;
  localparam int unsigned CALM_LAST       = 1000;
  // Comfortably above the pipeline latency.
  localparam int unsigned DRAIN_CYCLES    = 40;
  localparam int unsigned RUN_LIMIT_NS    = 2_000_000;

  // One converted pixel, laid out as the result channel carries it.
  typedef struct packed {
    logic [HUE_BITS-1:0]  hue;
    logic [SAT_BITS-1:0]  sat;
    logic [COMP_BITS-1:0] val;
  } hsv_t;

  // A row of the directed table. Where typed_result is set, the expected
  // result is written out by hand; otherwise the predictor supplies it.
  typedef struct packed {
    logic [COMP_BITS-1:0] red;
    logic [COMP_BITS-1:0] green;
    logic [COMP_BITS-1:0] blue;
    bit                   typed_result;
    hsv_t                 result;
  } pixel_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [COMP_BITS-1:0] red_i;
  logic [COMP_BITS-1:0] green_i;
  logic [COMP_BITS-1:0] blue_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [HUE_BITS-1:0]  hue_o;
  logic [SAT_BITS-1:0]  saturation_o;
  logic [COMP_BITS-1:0] value_o;

  hsv_t        hsv_expected[$];
  hsv_t        oldest_hsv;
  int unsigned results_seen = 0;
  int unsigned fail_count   = 0;

  // Hand-checked rows cover black, white, greys and the six pure hues,
  // including both kinds of tie and the magenta wrap below zero degrees.
  // The remaining rows probe small deltas, the wrap just under 360 degrees
  // and the negative offset in every sector, and go to the predictor.
  pixel_row_t directed_rows [NUM_DIRECTED] = '{
    '{8'd0,   8'd0,   8'd0,   1'b1, '{15'd0,     9'd0,   8'd0}},
    '{8'd255, 8'd255, 8'd255, 1'b1, '{15'd0,     9'd0,   8'd255}},
    '{8'd128, 8'd128, 8'd128, 1'b1, '{15'd0,     9'd0,   8'd128}},
    '{8'd1,   8'd1,   8'd1,   1'b1, '{15'd0,     9'd0,   8'd1}},
    '{8'd255, 8'd0,   8'd0,   1'b1, '{15'd0,     9'd256, 8'd255}},
    '{8'd0,   8'd255, 8'd0,   1'b1, '{15'd7680,  9'd256, 8'd255}},
    '{8'd0,   8'd0,   8'd255, 1'b1, '{15'd15360, 9'd256, 8'd255}},
    '{8'd255, 8'd255, 8'd0,   1'b1, '{15'd3840,  9'd256, 8'd255}},
    '{8'd0,   8'd255, 8'd255, 1'b1, '{15'd11520, 9'd256, 8'd255}},
    '{8'd255, 8'd0,   8'd255, 1'b1, '{15'd19200, 9'd256, 8'd255}},
    '{8'd1,   8'd0,   8'd0,   1'b1, '{15'd0,     9'd256, 8'd1}},
    '{8'd0,   8'd0,   8'd1,   1'b1, '{15'd15360, 9'd256, 8'd1}},
    '{8'd255, 8'd0,   8'd1,   1'b0, '0},
    '{8'd2,   8'd0,   8'd1,   1'b0, '0},
    '{8'd255, 8'd254, 8'd254, 1'b0, '0},
    '{8'd5,   8'd255, 8'd0,   1'b0, '0},
    '{8'd1,   8'd2,   8'd255, 1'b0, '0},
    '{8'd170, 8'd85,  8'd0,   1'b0, '0},
    '{8'd85,  8'd170, 8'd255, 1'b0, '0},
    '{8'd254, 8'd255, 8'd253, 1'b0, '0}
  };

  rgb_to_hsv_converter_core #(
    .COMPONENT_BITS(COMP_BITS),
    .HUE_FRAC_BITS (HUE_FRAC),
    .SAT_FRAC_BITS (SAT_FRAC)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .hue_o       (hue_o),
    .saturation_o(saturation_o),
    .value_o     (value_o)
  );

  // 12 ns clock period.
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Computes the HSV form of one pixel. The hue offset is 60 degrees times
  // the signed difference of the two other components over the spread,
  // truncated toward zero, then added to the base angle of the dominant
  // component; a negative total wraps round by a full turn.
  function automatic hsv_t convert_pixel(input logic [COMP_BITS-1:0] r,
                                         input logic [COMP_BITS-1:0] g,
                                         input logic [COMP_BITS-1:0] b);
    hsv_t                 res;
    logic [COMP_BITS-1:0] hi;
    logic [COMP_BITS-1:0] lo;
    logic [COMP_BITS-1:0] minuend;
    logic [COMP_BITS-1:0] subtrahend;
    sector_e              dominant;
    int unsigned          spread;
    int unsigned          base_deg;
    int unsigned          mag;
    int unsigned          offset;
    bit                   neg;
    int                   angle;
    hi = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    lo = r;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    spread = 32'(hi) - 32'(lo);
    res.hue = '0;
    res.sat = '0;
    res.val = hi;
    // A grey or black pixel has no hue and no saturation.
    if (spread != 0) begin
      res.sat = SAT_BITS'((spread << SAT_FRAC) / int'(hi));
      // Ties go to red first, then to green.
      if (hi == r) dominant = SECTOR_RED;
      else if (hi == g) dominant = SECTOR_GREEN;
      else dominant = SECTOR_BLUE;
      case (dominant)
        SECTOR_RED: begin
          base_deg = 0;
          minuend = g;
          subtrahend = b;
        end
        SECTOR_GREEN: begin
          base_deg = HUE_GREEN_DEG;
          minuend = b;
          subtrahend = r;
        end
        default: begin
          base_deg = HUE_BLUE_DEG;
          minuend = r;
          subtrahend = g;
        end
      endcase
      neg = minuend < subtrahend;
      mag = neg ? 32'(subtrahend) - 32'(minuend) : 32'(minuend) - 32'(subtrahend);
      offset = ((HUE_SECTOR_DEG * mag) << HUE_FRAC) / spread;
      angle = int'(base_deg << HUE_FRAC);
      angle = neg ? angle - int'(offset) : angle + int'(offset);
      if (angle < 0) angle = angle + int'(HUE_FULL_DEG << HUE_FRAC);
      res.hue = angle[HUE_BITS-1:0];
    end
    return res;
  endfunction

  // Presents one pixel and holds it until the input transfer happens, then
  // records the result that it must produce.
  task automatic offer_pixel(input logic [COMP_BITS-1:0] r,
                             input logic [COMP_BITS-1:0] g,
                             input logic [COMP_BITS-1:0] b,
                             input hsv_t                 result);
    in_valid_i <= 1'b1;
    red_i      <= r;
    green_i    <= g;
    blue_i     <= b;
    do @(posedge clk_i); while (!in_ready_o);
    hsv_expected.push_back(result);
  endtask

  // Between pixels the sender sometimes lets valid drop for a random gap,
  // except while the calm window is running.
  task automatic sender_gap();
    if ((results_seen < CALM_FIRST || results_seen >= CALM_LAST) &&
        $urandom_range(0, 99) < 10) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
  endtask

  // Sender: reset, then the directed table, then random pixels.
  initial begin
    logic [COMP_BITS-1:0] r;
    logic [COMP_BITS-1:0] g;
    logic [COMP_BITS-1:0] b;
    logic [COMP_BITS-1:0] level;
    int unsigned          style;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    red_i      <= '0;
    green_i    <= '0;
    blue_i     <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      offer_pixel(directed_rows[i].red, directed_rows[i].green, directed_rows[i].blue,
                  directed_rows[i].typed_result ? directed_rows[i].result
                  : convert_pixel(directed_rows[i].red, directed_rows[i].green,
                                  directed_rows[i].blue));
      sender_gap();
    end

    // Random pixels. Besides uniform noise, the mix favours greys, ties for
    // the largest component, values near the ends of the range and pixels
    // whose components sit close together, where truncation matters most.
    for (int unsigned n = 0; n < RANDOM_PIXELS; n++) begin
      style = $urandom_range(0, 9);
      r = COMP_BITS'($urandom);
      g = COMP_BITS'($urandom);
      b = COMP_BITS'($urandom);
      case (style)
        4: begin
          g = r;
          b = r;
        end
        5: begin
          if (r < g) r = g;
          case ($urandom_range(0, 2))
            0: g = r;
            1: b = r;
            default: begin
              b = g;
              if (b < r) b = r;
              g = b;
            end
          endcase
        end
        6: begin
          r = $urandom_range(0, 1) ? COMP_BITS'($urandom_range(0, 1))
              : COMP_BITS'($urandom_range(254, 255));
          g = $urandom_range(0, 1) ? COMP_BITS'($urandom_range(0, 1))
              : COMP_BITS'($urandom_range(254, 255));
          b = $urandom_range(0, 1) ? COMP_BITS'($urandom_range(0, 1))
              : COMP_BITS'($urandom_range(254, 255));
        end
        7: begin
          level = COMP_BITS'($urandom_range(3, 252));
          r = level + COMP_BITS'($urandom_range(0, 6)) - COMP_BITS'(3);
          g = level + COMP_BITS'($urandom_range(0, 6)) - COMP_BITS'(3);
          b = level + COMP_BITS'($urandom_range(0, 6)) - COMP_BITS'(3);
        end
        8: r = '1;
        9: b = '1;
        default: ;
      endcase
      offer_pixel(r, g, b, convert_pixel(r, g, b));
      sender_gap();
    end
    in_valid_i <= 1'b0;

    // Let the pipeline empty, then allow time for any stray extra result.
    while (hsv_expected.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Receiver: mostly ready, with short random stalls, one calm window and a
  // single long hold-off during which the pipeline fills and in_ready_o must
  // fall while the sender keeps offering.
  initial begin
    bit held_off;
    held_off = 1'b0;
    out_ready_i <= 1'b0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      if (!held_off && results_seen >= HOLD_OFF_AT) begin
        held_off = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else if (results_seen >= CALM_FIRST && results_seen < CALM_LAST) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= 10);
      end
    end
  end

  // Each result transfer is compared with the oldest outstanding pixel.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (hsv_expected.size() == 0) begin
        $error("result transferred with no pixel outstanding");
        fail_count++;
      end else begin
        oldest_hsv = hsv_expected.pop_front();
        if (hue_o !== oldest_hsv.hue) begin
          $error("hue: expected %0d, got %0d", oldest_hsv.hue, hue_o);
          fail_count++;
        end
        if (saturation_o !== oldest_hsv.sat) begin
          $error("saturation: expected %0d, got %0d", oldest_hsv.sat, saturation_o);
          fail_count++;
        end
        if (value_o !== oldest_hsv.val) begin
          $error("value: expected %0d, got %0d", oldest_hsv.val, value_o);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: a run that hangs ends here.
  initial begin
    #(RUN_LIMIT_NS);
    $display("Test completed with failures");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/rhc_pkg.sv
design/rhc_front.sv
design/rhc_div.sv
design/rhc_back.sv
design/rgb_to_hsv_converter_core.sv
tb/tb_rgb_to_hsv_converter_core.sv
